[rtl/gbmu_pkg.sv]
// Shared types and constants of the buffer memory unit: command and
// address mode codes, and the index of the last byte of each command.
// No dependencies.
`default_nettype none

package gbmu_pkg;

    // Commands
    localparam logic [3:0] CMD_LD_UBYTE   = 4'd0;
    localparam logic [3:0] CMD_LD_SBYTE   = 4'd1;
    localparam logic [3:0] CMD_LD_WORD1   = 4'd2;
    localparam logic [3:0] CMD_LD_WORD2   = 4'd3;
    localparam logic [3:0] CMD_LD_WORD4   = 4'd4;
    localparam logic [3:0] CMD_ST_BYTE    = 4'd5;
    localparam logic [3:0] CMD_ST_WORD1   = 4'd6;
    localparam logic [3:0] CMD_ST_WORD2   = 4'd7;
    localparam logic [3:0] CMD_ST_WORD4   = 4'd8;
    localparam logic [3:0] CMD_ATOMIC     = 4'd9;
    localparam logic [3:0] CMD_ATOMIC_RET = 4'd10;

    // Address modes
    localparam logic [2:0] MODE_OFFSET    = 3'd1;
    localparam logic [2:0] MODE_INDEX     = 3'd2;
    localparam logic [2:0] MODE_IDX_OFF   = 3'd3;
    localparam logic [2:0] MODE_ADDR64    = 3'd4;

    typedef logic [3:0] byte_cnt_t;

    // Index of the final byte touched in one read or write pass
    function automatic byte_cnt_t last_byte(input logic [3:0] cmd);
        byte_cnt_t n;
        case (cmd)
            CMD_LD_WORD1, CMD_ST_WORD1, CMD_ATOMIC, CMD_ATOMIC_RET: n = 4'd3;
            CMD_LD_WORD2, CMD_ST_WORD2:                             n = 4'd7;
            CMD_LD_WORD4, CMD_ST_WORD4:                             n = 4'd15;
            default:                                                n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

[rtl/gbmu_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module gbmu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write when enabled, read every cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

[rtl/gpu_buffer_memory_unit.sv]
// Buffer load/store unit for one lane: address generation and byte memory.
// Depends on gbmu_pkg and gbmu_ram.
// Usage:
//   A request transaction (request_valid high, request_stall low) carries one
//   buffer command. The unit then stalls its request channel until the command
//   is done. Results leave on the result channel, one transaction per loaded
//   word and one for every other command; nop and unused commands give none.
//   The address is formed by a multiply and then the final add, and is
//   then reduced modulo the memory size by a reciprocal multiply, a
//   multiply back and one conditional subtract. The single byte-wide
//   memory port then moves one byte per cycle for writes, while each byte
//   read passes through a read state and then a capture state.
//   A finished result sits in an output register; the unit takes the next
//   request the cycle after loading it, while the result waits. If
//   result_stall stays high, the unit holds at its next result until the
//   register is free.
//   Reset clears the control state and the result channel. Memory contents
//   are undefined until written.
`default_nettype none

module gpu_buffer_memory_unit #(
    parameter int MEM_BYTES = 65536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        request_valid,
    output logic             request_stall,
    input  wire logic [3:0]  command,
    input  wire logic [31:0] base_address,
    input  wire logic [13:0] stride,
    input  wire logic [31:0] scalar_offset,
    input  wire logic [11:0] inst_offset,
    input  wire logic [2:0]  address_mode,
    input  wire logic [31:0] vector_word_a,
    input  wire logic [31:0] vector_word_b,
    input  wire logic [5:0]  lane_index,
    input  wire logic [63:0] store_data_low,
    input  wire logic [63:0] store_data_high,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [31:0]      address,
    output logic [31:0]      data,
    output logic [1:0]       word_index,
    output logic             last,
    output logic             address_overflow
);

    localparam int ADDR_W = $clog2(MEM_BYTES);
    localparam logic [ADDR_W-1:0] MEM_LAST = ADDR_W'(MEM_BYTES - 1);
    localparam logic [31:0]       MEM_WORD = 32'(MEM_BYTES);
    // Reciprocal of the memory size; the quotient estimate is low by at most one
    localparam int                RECIP_SHIFT = 31 + ADDR_W;
    localparam logic [63:0]       RECIP_WIDE  = (64'd1 << RECIP_SHIFT) / 64'(MEM_BYTES);
    localparam logic [31:0]       RECIP       = RECIP_WIDE[31:0];

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_CAP  = 3'd5;
    localparam logic [2:0] S_WR   = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0]              state_reg, state_next;
    logic [3:0]              cmd_reg, cmd_next;
    logic [31:0]             base_reg, base_next;
    logic [13:0]             stride_reg, stride_next;
    logic [31:0]             soff_reg, soff_next;
    logic [11:0]             ioff_reg, ioff_next;
    logic [2:0]              mode_reg, mode_next;
    logic [31:0]             va_reg, va_next;
    logic [31:0]             vb_reg, vb_next;
    logic [5:0]              lane_reg, lane_next;
    logic [127:0]            wdata_reg, wdata_next;
    logic [31:0]             prod_reg, prod_next;
    logic [33:0]             part_reg, part_next;
    logic [31:0]             addr_reg, addr_next;
    logic                    ovf_reg, ovf_next;
    logic [31:0]             cur_addr_reg, cur_addr_next;
    logic [ADDR_W-1:0]       slot_reg, slot_next;
    logic [ADDR_W-1:0]       start_slot_reg, start_slot_next;
    logic [1:0]              mod_cnt_reg, mod_cnt_next;
    logic [31:0]             quo_reg, quo_next;
    logic [31:0]             rem_reg, rem_next;
    gbmu_pkg::byte_cnt_t     byte_cnt_reg, byte_cnt_next;
    logic [31:0]             word_reg, word_next;
    logic                    out_valid_reg, out_valid_next;
    logic [31:0]             address_reg, address_next;
    logic [31:0]             data_reg, data_next;
    logic [1:0]              word_index_reg, word_index_next;
    logic                    last_reg, last_next;
    logic                    overflow_reg, overflow_next;

    logic [31:0]             idx_sum;
    logic [45:0]             prod_full;
    logic [31:0]             off_word;
    logic [64:0]             sum64;
    logic [63:0]             recip_prod;
    logic [ADDR_W-1:0]       slot_inc;
    logic [31:0]             assembled;
    logic                    is_load;
    logic                    emit_last;
    logic                    out_free;
    gbmu_pkg::byte_cnt_t     final_byte;
    logic                    ram_we;
    logic [7:0]              ram_rdata;

    gbmu_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (slot_reg),
        .wdata (wdata_reg[7:0]),
        .rdata (ram_rdata)
    );

    // Datapath helpers
    always_comb
    begin
        idx_sum   = ((mode_reg == gbmu_pkg::MODE_INDEX) || (mode_reg == gbmu_pkg::MODE_IDX_OFF))
                    ? va_reg + {26'd0, lane_reg} : {26'd0, lane_reg};
        prod_full = stride_reg * idx_sum;
        if (mode_reg == gbmu_pkg::MODE_OFFSET)
        begin
            off_word = va_reg;
        end
        else if (mode_reg == gbmu_pkg::MODE_IDX_OFF)
        begin
            off_word = vb_reg;
        end
        else
        begin
            off_word = 32'd0;
        end
        sum64      = {1'b0, vb_reg, va_reg} + {31'd0, part_reg};
        recip_prod = {32'd0, cur_addr_reg} * {32'd0, RECIP};
        slot_inc   = ((cur_addr_reg == 32'hFFFF_FFFF) || (slot_reg == MEM_LAST))
                     ? '0 : slot_reg + ADDR_W'(1);
        assembled  = {ram_rdata, word_reg[31:8]};
        is_load    = cmd_reg inside {[gbmu_pkg::CMD_LD_UBYTE : gbmu_pkg::CMD_LD_WORD4]};
        final_byte = gbmu_pkg::last_byte(cmd_reg);
        emit_last  = !is_load || (byte_cnt_reg == final_byte);
        out_free   = !out_valid_reg || !result_stall;
    end

    // Sequencer and datapath next state
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        base_next       = base_reg;
        stride_next     = stride_reg;
        soff_next       = soff_reg;
        ioff_next       = ioff_reg;
        mode_next       = mode_reg;
        va_next         = va_reg;
        vb_next         = vb_reg;
        lane_next       = lane_reg;
        wdata_next      = wdata_reg;
        prod_next       = prod_reg;
        part_next       = part_reg;
        addr_next       = addr_reg;
        ovf_next        = ovf_reg;
        cur_addr_next   = cur_addr_reg;
        slot_next       = slot_reg;
        start_slot_next = start_slot_reg;
        mod_cnt_next    = mod_cnt_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        byte_cnt_next   = byte_cnt_reg;
        word_next       = word_reg;
        out_valid_next  = out_valid_reg && result_stall;
        address_next    = address_reg;
        data_next       = data_reg;
        word_index_next = word_index_reg;
        last_next       = last_reg;
        overflow_next   = overflow_reg;
        ram_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                // Capture the request; drop nop and unused commands
                if (request_valid)
                begin
                    cmd_next    = command;
                    base_next   = base_address;
                    stride_next = stride;
                    soff_next   = scalar_offset;
                    ioff_next   = inst_offset;
                    mode_next   = address_mode;
                    va_next     = vector_word_a;
                    vb_next     = vector_word_b;
                    lane_next   = lane_index;
                    wdata_next  = {store_data_high, store_data_low};
                    if (command <= gbmu_pkg::CMD_ATOMIC_RET)
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                // Stride product and constant offsets
                prod_next  = prod_full[31:0];
                part_next  = {2'b0, base_reg} + {2'b0, soff_reg} + {22'd0, ioff_reg};
                state_next = S_SUM;
            end
            S_SUM:
            begin
                // Final byte address
                if (mode_reg == gbmu_pkg::MODE_ADDR64)
                begin
                    addr_next = sum64[31:0];
                    ovf_next  = |sum64[64:32];
                end
                else
                begin
                    addr_next = part_reg[31:0] + off_word + prod_reg;
                    ovf_next  = 1'b0;
                end
                cur_addr_next = (mode_reg == gbmu_pkg::MODE_ADDR64)
                                ? sum64[31:0] : part_reg[31:0] + off_word + prod_reg;
                mod_cnt_next  = 2'd2;
                state_next    = S_MOD;
            end
            S_MOD:
            begin
                // Reduce the address modulo the memory size: estimate the
                // quotient, multiply back, then correct with one subtract
                mod_cnt_next = mod_cnt_reg - 2'd1;
                case (mod_cnt_reg)
                    2'd2:
                    begin
                        quo_next = 32'(recip_prod >> RECIP_SHIFT);
                    end
                    2'd1:
                    begin
                        rem_next = cur_addr_reg - quo_reg * MEM_WORD;
                    end
                    default:
                    begin
                        slot_next       = (rem_reg >= MEM_WORD)
                                          ? ADDR_W'(rem_reg - MEM_WORD) : ADDR_W'(rem_reg);
                        start_slot_next = slot_next;
                        byte_cnt_next   = '0;
                        if (cmd_reg inside {[gbmu_pkg::CMD_ST_BYTE : gbmu_pkg::CMD_ST_WORD4]})
                        begin
                            state_next = S_WR;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                endcase
            end
            S_RD:
            begin
                // Read issued at the current slot
                state_next = S_CAP;
            end
            S_CAP:
            begin
                // Take the byte and advance the pointer
                cur_addr_next = cur_addr_reg + 32'd1;
                slot_next     = slot_inc;
                if (cmd_reg == gbmu_pkg::CMD_LD_UBYTE)
                begin
                    word_next  = {24'd0, ram_rdata};
                    state_next = S_EMIT;
                end
                else if (cmd_reg == gbmu_pkg::CMD_LD_SBYTE)
                begin
                    word_next  = {{24{ram_rdata[7]}}, ram_rdata};
                    state_next = S_EMIT;
                end
                else
                begin
                    word_next = assembled;
                    if (byte_cnt_reg[1:0] != 2'd3)
                    begin
                        byte_cnt_next = byte_cnt_reg + 4'd1;
                        state_next    = S_RD;
                    end
                    else if (cmd_reg inside {gbmu_pkg::CMD_ATOMIC, gbmu_pkg::CMD_ATOMIC_RET})
                    begin
                        // Rewind to the word and write back the sum
                        wdata_next    = {wdata_reg[127:32], assembled + wdata_reg[31:0]};
                        cur_addr_next = addr_reg;
                        slot_next     = start_slot_reg;
                        byte_cnt_next = '0;
                        state_next    = S_WR;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_WR:
            begin
                // Write one byte and advance
                ram_we        = 1'b1;
                wdata_next    = {8'd0, wdata_reg[127:8]};
                cur_addr_next = cur_addr_reg + 32'd1;
                slot_next     = slot_inc;
                if (byte_cnt_reg == final_byte)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    byte_cnt_next = byte_cnt_reg + 4'd1;
                end
            end
            S_EMIT:
            begin
                // Load the output register once it is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    overflow_next   = ovf_reg;
                    last_next       = emit_last;
                    word_index_next = is_load ? byte_cnt_reg[3:2] : 2'd0;
                    address_next    = is_load
                                      ? addr_reg + {26'd0, byte_cnt_reg[3:2], 2'b00} : addr_reg;
                    data_next       = (is_load || (cmd_reg == gbmu_pkg::CMD_ATOMIC_RET))
                                      ? word_reg : 32'd0;
                    if (emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        byte_cnt_next = byte_cnt_reg + 4'd1;
                        state_next    = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            mod_cnt_reg   <= '0;
            byte_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            mod_cnt_reg   <= mod_cnt_next;
            byte_cnt_reg  <= byte_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        base_reg       <= base_next;
        stride_reg     <= stride_next;
        soff_reg       <= soff_next;
        ioff_reg       <= ioff_next;
        mode_reg       <= mode_next;
        va_reg         <= va_next;
        vb_reg         <= vb_next;
        lane_reg       <= lane_next;
        wdata_reg      <= wdata_next;
        prod_reg       <= prod_next;
        part_reg       <= part_next;
        addr_reg       <= addr_next;
        ovf_reg        <= ovf_next;
        cur_addr_reg   <= cur_addr_next;
        slot_reg       <= slot_next;
        start_slot_reg <= start_slot_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        word_reg       <= word_next;
        address_reg    <= address_next;
        data_reg       <= data_next;
        word_index_reg <= word_index_next;
        last_reg       <= last_next;
        overflow_reg   <= overflow_next;
    end

    assign request_stall    = (state_reg != S_IDLE);
    assign result_valid     = out_valid_reg;
    assign address          = address_reg;
    assign data             = data_reg;
    assign word_index       = word_index_reg;
    assign last             = last_reg;
    assign address_overflow = overflow_reg;

`ifndef NO_ASSERTIONS
    // Memory slot stays inside the memory during accesses
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RD) || (state_reg == S_WR)) |-> (slot_reg <= MEM_LAST))
        else $error("memory slot out of range");

    // Byte counter never runs past the command's last byte
    a_byte_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_RD) || (state_reg == S_CAP) || (state_reg == S_WR))
        |-> (byte_cnt_reg <= final_byte))
        else $error("byte counter overrun");

    // Only stores and atomics write memory
    a_write_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((cmd_reg >= gbmu_pkg::CMD_ST_BYTE) && (cmd_reg <= gbmu_pkg::CMD_ATOMIC_RET)))
        else $error("memory write by a load");

    // A pending result is never overwritten while stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_stall && (state_reg == S_EMIT)) |=> (state_reg == S_EMIT))
        else $error("result overwritten under stall");
`endif

endmodule

`default_nettype wire

[test/gpu_buffer_memory_unit_checker.sv]
`timescale 1ns / 1ps
// Checker for the buffer memory unit: watches the request and result channels.
// It predicts every result from its own byte-memory image and compares them.
// Depends on gbmu_pkg.

module gpu_buffer_memory_unit_checker #(
    parameter int MEM_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        request_valid,
    input  logic        request_stall,
    input  logic [3:0]  command,
    input  logic [31:0] base_address,
    input  logic [13:0] stride,
    input  logic [31:0] scalar_offset,
    input  logic [11:0] inst_offset,
    input  logic [2:0]  address_mode,
    input  logic [31:0] vector_word_a,
    input  logic [31:0] vector_word_b,
    input  logic [5:0]  lane_index,
    input  logic [63:0] store_data_low,
    input  logic [63:0] store_data_high,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [31:0] address,
    input  logic [31:0] data,
    input  logic [1:0]  word_index,
    input  logic        last,
    input  logic        address_overflow,
    output int          failures,
    output int          pending
);

    typedef struct packed {
        logic [31:0] address;
        logic [31:0] data;
        logic [1:0]  word_index;
        logic        last;
        logic        overflow;
    } access_result_t;

    access_result_t result_q[$];
    logic [7:0]     mem_image [MEM_BYTES];

    initial
    begin
        failures = 0;
        pending  = 0;
        for (int k = 0; k < MEM_BYTES; k++)
            mem_image[k] = 8'h00;
    end

    function automatic int unsigned slot(logic [31:0] a);
        return a % MEM_BYTES;
    endfunction

    // Assemble a little-endian word; byte addresses wrap at 32 bits first
    function automatic logic [31:0] fetch_word(logic [31:0] a);
        logic [31:0] w;
        w = '0;
        for (int k = 0; k < 4; k++)
            w[8*k +: 8] = mem_image[slot(a + 32'(k))];
        return w;
    endfunction

    function automatic void put_word(logic [31:0] a, logic [31:0] w);
        for (int k = 0; k < 4; k++)
            mem_image[slot(a + 32'(k))] = w[8*k +: 8];
    endfunction

    function automatic void push(logic [31:0] a, logic [31:0] d, logic [1:0] idx,
                                 logic fin, logic ovf);
        access_result_t r;
        r.address    = a;
        r.data       = d;
        r.word_index = idx;
        r.last       = fin;
        r.overflow   = ovf;
        result_q.push_back(r);
    endfunction

    task automatic report(string what);
        failures++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Execute one accepted command on the image and queue its results
    task automatic predict_request();
        logic [31:0] at, off, idx, wa, old;
        logic [31:0] sw [4];
        logic [65:0] wide;
        logic [7:0]  b;
        logic        ovf;
        int          n;
        off = '0;
        idx = '0;
        ovf = 1'b0;
        at  = '0;
        sw[0] = store_data_low[31:0];
        sw[1] = store_data_low[63:32];
        sw[2] = store_data_high[31:0];
        sw[3] = store_data_high[63:32];
        case (address_mode)
            gbmu_pkg::MODE_ADDR64:
            begin
                wide = {2'b00, vector_word_b, vector_word_a} + 66'(base_address)
                     + 66'(inst_offset) + 66'(scalar_offset);
                at  = wide[31:0];
                ovf = |wide[65:32];
            end
            gbmu_pkg::MODE_OFFSET:  off = vector_word_a;
            gbmu_pkg::MODE_INDEX:   idx = vector_word_a;
            gbmu_pkg::MODE_IDX_OFF:
            begin
                idx = vector_word_a;
                off = vector_word_b;
            end
            default: ;
        endcase
        if (address_mode != gbmu_pkg::MODE_ADDR64)
            at = base_address + scalar_offset + 32'(inst_offset) + off
               + 32'(stride) * (idx + 32'(lane_index));

        case (command)
            gbmu_pkg::CMD_LD_UBYTE:
                push(at, {24'h0, mem_image[slot(at)]}, 2'd0, 1'b1, ovf);
            gbmu_pkg::CMD_LD_SBYTE:
            begin
                b = mem_image[slot(at)];
                push(at, {{24{b[7]}}, b}, 2'd0, 1'b1, ovf);
            end
            gbmu_pkg::CMD_LD_WORD1, gbmu_pkg::CMD_LD_WORD2, gbmu_pkg::CMD_LD_WORD4:
            begin
                n = (command == gbmu_pkg::CMD_LD_WORD1) ? 1
                  : (command == gbmu_pkg::CMD_LD_WORD2) ? 2 : 4;
                for (int i = 0; i < n; i++)
                begin
                    wa = at + 32'(4 * i);
                    push(wa, fetch_word(wa), 2'(i), i == n - 1, ovf);
                end
            end
            gbmu_pkg::CMD_ST_BYTE:
            begin
                mem_image[slot(at)] = store_data_low[7:0];
                push(at, '0, 2'd0, 1'b1, ovf);
            end
            gbmu_pkg::CMD_ST_WORD1, gbmu_pkg::CMD_ST_WORD2, gbmu_pkg::CMD_ST_WORD4:
            begin
                n = (command == gbmu_pkg::CMD_ST_WORD1) ? 1
                  : (command == gbmu_pkg::CMD_ST_WORD2) ? 2 : 4;
                for (int i = 0; i < n; i++)
                    put_word(at + 32'(4 * i), sw[i]);
                push(at, '0, 2'd0, 1'b1, ovf);
            end
            gbmu_pkg::CMD_ATOMIC, gbmu_pkg::CMD_ATOMIC_RET:
            begin
                old = fetch_word(at);
                put_word(at, old + sw[0]);
                push(at, (command == gbmu_pkg::CMD_ATOMIC_RET) ? old : '0, 2'd0, 1'b1, ovf);
            end
            default: ;  // nop and unused codes: no access, no result
        endcase
    endtask

    // Compare one result transaction with the oldest prediction
    task automatic check_result();
        access_result_t want;
        if (result_q.size() == 0)
        begin
            report($sformatf("result with none expected: address %h data %h",
                             address, data));
            return;
        end
        want = result_q.pop_front();
        if (address !== want.address)
            report($sformatf("address %h, expected %h", address, want.address));
        if (data !== want.data)
            report($sformatf("data %h, expected %h at address %h",
                             data, want.data, want.address));
        if (word_index !== want.word_index)
            report($sformatf("word_index %0d, expected %0d at address %h",
                             word_index, want.word_index, want.address));
        if (last !== want.last)
            report($sformatf("last %b, expected %b at address %h",
                             last, want.last, want.address));
        if (address_overflow !== want.overflow)
            report($sformatf("address_overflow %b, expected %b at address %h",
                             address_overflow, want.overflow, want.address));
    endtask

    // Sample both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (request_valid && !request_stall)
                predict_request();
            if (result_valid && !result_stall)
                check_result();
        end
        pending = result_q.size();
    end

endmodule

[test/gpu_buffer_memory_unit_tb.sv]
`timescale 1ns / 1ps
// Top of the buffer memory unit testbench: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on gbmu_pkg, the unit and
// gpu_buffer_memory_unit_checker.

module gpu_buffer_memory_unit_tb;

    localparam int         MEM_BYTES    = 65536;
    localparam int         RANDOM_ITEMS = 220;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         WINDOW       = 192;   // bytes around memory slot zero
    localparam logic [3:0] CMD_NOP      = 4'd11;
    localparam int         CMD_TOP      = 15;
    localparam logic [2:0] MODE_NONE    = 3'd0;
    localparam int         MODE_TOP     = 7;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [31:0] base;
        logic [13:0] stride;
        logic [31:0] soff;
        logic [11:0] ioff;
        logic [2:0]  mode;
        logic [31:0] va;
        logic [31:0] vb;
        logic [5:0]  lane;
        logic [63:0] lo;
        logic [63:0] hi;
    } buffer_request_t;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            request_valid;
    logic            request_stall;
    logic            result_valid;
    logic            result_stall;
    logic [31:0]     address;
    logic [31:0]     data;
    logic [1:0]      word_index;
    logic            last;
    logic            address_overflow;
    int              failures;
    int              pending;
    int              cycles = 0;
    bit              calm;
    bit              written [MEM_BYTES];
    buffer_request_t req;   // transaction being built
    buffer_request_t bus;   // transaction on the request channel

    always #1 clk = ~clk;

    gpu_buffer_memory_unit #(.MEM_BYTES(MEM_BYTES)) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .request_valid    (request_valid),
        .request_stall    (request_stall),
        .command          (bus.cmd),
        .base_address     (bus.base),
        .stride           (bus.stride),
        .scalar_offset    (bus.soff),
        .inst_offset      (bus.ioff),
        .address_mode     (bus.mode),
        .vector_word_a    (bus.va),
        .vector_word_b    (bus.vb),
        .lane_index       (bus.lane),
        .store_data_low   (bus.lo),
        .store_data_high  (bus.hi),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .address          (address),
        .data             (data),
        .word_index       (word_index),
        .last             (last),
        .address_overflow (address_overflow)
    );

    gpu_buffer_memory_unit_checker #(.MEM_BYTES(MEM_BYTES)) u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .request_valid    (request_valid),
        .request_stall    (request_stall),
        .command          (bus.cmd),
        .base_address     (bus.base),
        .stride           (bus.stride),
        .scalar_offset    (bus.soff),
        .inst_offset      (bus.ioff),
        .address_mode     (bus.mode),
        .vector_word_a    (bus.va),
        .vector_word_b    (bus.vb),
        .lane_index       (bus.lane),
        .store_data_low   (bus.lo),
        .store_data_high  (bus.hi),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .address          (address),
        .data             (data),
        .word_index       (word_index),
        .last             (last),
        .address_overflow (address_overflow),
        .failures         (failures),
        .pending          (pending)
    );

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 0;
        if (r < 17)
            return $urandom_range(1, 3);
        if (r < 19)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Random value of a field, biased toward its extremes
    function automatic logic [63:0] pick_val(int w);
        logic [63:0] mask;
        mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return mask;
            default: return {$urandom, $urandom} & mask;
        endcase
    endfunction

    // Low 32 bits of the access address; all that placement needs
    function automatic logic [31:0] form_addr(buffer_request_t r);
        logic [31:0] off, idx;
        off = '0;
        idx = '0;
        if (r.mode == gbmu_pkg::MODE_ADDR64)
            return r.va + r.base + 32'(r.ioff) + r.soff;
        if (r.mode == gbmu_pkg::MODE_OFFSET)
            off = r.va;
        else if (r.mode == gbmu_pkg::MODE_INDEX)
            idx = r.va;
        else if (r.mode == gbmu_pkg::MODE_IDX_OFF)
        begin
            idx = r.va;
            off = r.vb;
        end
        return r.base + r.soff + 32'(r.ioff) + off + 32'(r.stride) * (idx + 32'(r.lane));
    endfunction

    function automatic int span(logic [3:0] c);
        case (c)
            gbmu_pkg::CMD_LD_UBYTE, gbmu_pkg::CMD_LD_SBYTE, gbmu_pkg::CMD_ST_BYTE:
                return 1;
            gbmu_pkg::CMD_LD_WORD1, gbmu_pkg::CMD_ST_WORD1, gbmu_pkg::CMD_ATOMIC,
            gbmu_pkg::CMD_ATOMIC_RET:
                return 4;
            gbmu_pkg::CMD_LD_WORD2, gbmu_pkg::CMD_ST_WORD2:
                return 8;
            gbmu_pkg::CMD_LD_WORD4, gbmu_pkg::CMD_ST_WORD4:
                return 16;
            default:
                return 0;
        endcase
    endfunction

    function automatic bit reads_mem(logic [3:0] c);
        return c <= gbmu_pkg::CMD_LD_WORD4 || c == gbmu_pkg::CMD_ATOMIC
            || c == gbmu_pkg::CMD_ATOMIC_RET;
    endfunction

    function automatic bit writes_mem(logic [3:0] c);
        return c >= gbmu_pkg::CMD_ST_BYTE && c <= gbmu_pkg::CMD_ATOMIC_RET;
    endfunction

    function automatic bit filled(logic [31:0] at, int n);
        for (int k = 0; k < n; k++)
            if (!written[32'(at + 32'(k)) % MEM_BYTES])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void roll();
        req.cmd    = CMD_NOP;
        req.base   = 32'(pick_val(32));
        req.stride = 14'(pick_val(14));
        req.soff   = 32'(pick_val(32));
        req.ioff   = 12'(pick_val(12));
        req.mode   = 3'($urandom_range(0, MODE_TOP));
        req.va     = 32'(pick_val(32));
        req.vb     = 32'(pick_val(32));
        req.lane   = 6'(pick_val(6));
        req.lo     = pick_val(64);
        req.hi     = pick_val(64);
    endfunction

    // Solve base or scalar offset so the access lands on the target
    function automatic void aim(logic [31:0] target, bit via_soff);
        if (via_soff)
        begin
            req.soff = '0;
            req.soff = target - form_addr(req);
        end
        else
        begin
            req.base = '0;
            req.base = target - form_addr(req);
        end
    endfunction

    task automatic rest(int n);
        if (n > 0)
        begin
            @(negedge clk);
            request_valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Drive one request transaction and hold it until accepted
    task automatic post();
        logic [31:0] at;
        at = form_addr(req);
        if (writes_mem(req.cmd))
            for (int k = 0; k < span(req.cmd); k++)
                written[32'(at + 32'(k)) % MEM_BYTES] = 1'b1;
        @(negedge clk);
        bus = req;
        request_valid = 1'b1;
        @(posedge clk);
        while (request_stall)
            @(posedge clk);
        rest(calm ? 0 : idle_len());
    endtask

    // Hold off the sender until every predicted result has been seen
    task automatic drain();
        @(negedge clk);
        request_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Result side back-pressure
    initial
    begin : result_side
        int run, hold;
        result_stall = 1'b0;
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                              : $urandom_range(1, 6);
            repeat (run) @(negedge clk);
            hold = idle_len();
            if (hold > 0)
            begin
                result_stall = 1'b1;
                repeat (hold) @(negedge clk);
                result_stall = 1'b0;
            end
        end
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** gpu_buffer_memory_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [31:0] tgt;
        int          r, tries;
        rst_n         = 1'b0;
        request_valid = 1'b0;
        calm          = 1'b0;
        req           = '0;
        bus           = '0;
        for (int k = 0; k < MEM_BYTES; k++)
            written[k] = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Wide stores of all ones and all zeros, wide loads back, extreme address fields
        roll(); req.cmd = gbmu_pkg::CMD_ST_WORD4; req.lo = '1; req.hi = '1;
        aim(32'h0, 1'b0); post();
        roll(); req.cmd = gbmu_pkg::CMD_ST_WORD4; req.mode = MODE_NONE;
        req.lo = '0; req.hi = '0;
        req.lane = '1; req.stride = '1; req.ioff = '1; req.base = '1;
        aim(32'd16, 1'b1); post();
        roll(); req.cmd = gbmu_pkg::CMD_LD_WORD4; req.mode = gbmu_pkg::MODE_OFFSET;
        req.va = '1;
        aim(32'h0, 1'b1); post();
        roll(); req.cmd = gbmu_pkg::CMD_LD_WORD4; req.mode = gbmu_pkg::MODE_IDX_OFF;
        req.va = '1; req.vb = '1;
        aim(32'd16, 1'b0); post();

        // Byte stores and loads on both sides of the sign bit
        roll(); req.cmd = gbmu_pkg::CMD_ST_BYTE; req.lo[7:0] = 8'h80;
        aim(32'd2, 1'b0); post();
        roll(); req.cmd = gbmu_pkg::CMD_ST_BYTE; req.lo[7:0] = 8'h7F;
        aim(32'd3, 1'b1); post();
        roll(); req.cmd = gbmu_pkg::CMD_LD_SBYTE; aim(32'd2, 1'b0); post();
        roll(); req.cmd = gbmu_pkg::CMD_LD_SBYTE; aim(32'd3, 1'b1); post();
        roll(); req.cmd = gbmu_pkg::CMD_LD_UBYTE; aim(32'd2, 1'b0); post();

        // 64-bit addressing that overflows, across the memory end
        roll(); req.cmd = gbmu_pkg::CMD_ST_WORD2; req.mode = gbmu_pkg::MODE_ADDR64;
        req.va = '1; req.vb = '1;
        aim(32'hFFFF_FFFC, 1'b0); post();
        roll(); req.cmd = gbmu_pkg::CMD_LD_WORD2; req.mode = gbmu_pkg::MODE_ADDR64;
        req.va = '1; req.vb = '0;
        aim(32'hFFFF_FFFC, 1'b1); post();
        roll(); req.cmd = gbmu_pkg::CMD_LD_WORD1; req.mode = gbmu_pkg::MODE_ADDR64;
        req.va = '0; req.vb = '1;
        aim(32'hFFFF_FFFE, 1'b0); post();

        // Atomic add wrapping at 32 bits, with and without the old value
        roll(); req.cmd = gbmu_pkg::CMD_ST_WORD1; req.lo[31:0] = '1;
        aim(32'd32, 1'b0); post();
        roll(); req.cmd = gbmu_pkg::CMD_ATOMIC; req.lo[31:0] = 32'd1;
        aim(32'd32, 1'b1); post();
        roll(); req.cmd = gbmu_pkg::CMD_ATOMIC_RET; req.lo[31:0] = '1;
        aim(32'd32, 1'b0); post();
        roll(); req.cmd = gbmu_pkg::CMD_ATOMIC_RET; req.lo[31:0] = 32'h1234_5678;
        aim(32'd32, 1'b1); post();
        roll(); req.cmd = gbmu_pkg::CMD_LD_WORD1; req.mode = gbmu_pkg::MODE_INDEX;
        req.stride = '0;
        req.lane = '0; req.va = '0; aim(32'd32, 1'b0); post();

        // Unused address modes behave as no vector word
        for (int m = gbmu_pkg::MODE_ADDR64 + 1; m <= MODE_TOP; m++)
        begin
            roll(); req.cmd = gbmu_pkg::CMD_LD_WORD1; req.mode = 3'(m);
            aim(32'h0, m[0]); post();
        end

        // Nop and unused commands give no result
        for (int c = CMD_NOP; c <= CMD_TOP; c++)
        begin
            roll(); req.cmd = 4'(c); post();
        end
        drain();

        // Random mix inside a small window so loads hit written bytes
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 39)
                drain();
            if (i % 30 == 0)
                calm = ($urandom_range(0, 2) == 0);
            roll();
            r = $urandom_range(0, 99);
            if (r < 38)
                req.cmd = 4'($urandom_range(gbmu_pkg::CMD_LD_UBYTE, gbmu_pkg::CMD_LD_WORD4));
            else if (r < 70)
                req.cmd = 4'($urandom_range(gbmu_pkg::CMD_ST_BYTE, gbmu_pkg::CMD_ST_WORD4));
            else if (r < 88)
                req.cmd = ($urandom_range(0, 1) == 0) ? gbmu_pkg::CMD_ATOMIC
                                                      : gbmu_pkg::CMD_ATOMIC_RET;
            else
                req.cmd = 4'($urandom_range(CMD_NOP, CMD_TOP));
            tries = 0;
            do
            begin
                tgt = $urandom;
                tgt[15:0] = 16'($urandom_range(0, WINDOW - 1) - WINDOW / 2);
                tries++;
            end
            while (reads_mem(req.cmd) && !filled(tgt, span(req.cmd)) && tries < 8);
            // Turn a read of unwritten bytes into a wide store there
            if (reads_mem(req.cmd) && !filled(tgt, span(req.cmd)))
                req.cmd = gbmu_pkg::CMD_ST_WORD4;
            aim(tgt, $urandom_range(0, 1));
            post();
        end

        drain();
        repeat (120) @(negedge clk);
        if (failures == 0)
            $display("** gpu_buffer_memory_unit: PASSED **");
        else
            $display("** gpu_buffer_memory_unit: FAILED **");
        $finish;
    end

endmodule

[sim.f]
rtl/gbmu_pkg.sv
rtl/gbmu_ram.sv
rtl/gpu_buffer_memory_unit.sv
test/gpu_buffer_memory_unit_checker.sv
test/gpu_buffer_memory_unit_tb.sv
